FILE: rtl/core/sfrcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfrcd_pkg
// Shared types and constants for the sync frame receiver and command decoder.
// ----------------------------------------------------------------------------
package sfrcd_pkg;

    localparam logic [7:0] HDR0      = 8'h8A;
    localparam logic [7:0] HDR1      = 8'h8B;
    localparam logic [7:0] HDR2      = 8'h1C;
    localparam logic [7:0] OP_CAL3   = 8'hAA;
    localparam logic [7:0] OP_CAL4   = 8'hA3;
    localparam logic [7:0] OP_READ   = 8'hAD;
    localparam logic [7:0] OP_LOAD   = 8'hAE;
    localparam logic [7:0] START_RST = 8'h8A;

    localparam int GAIN_BASE = 4;
    localparam int GAIN_COUNT = 9;
    localparam logic [3:0] GAIN_LAST = 4'(GAIN_COUNT - 1);

    localparam logic [1:0] CMD_INVALID   = 2'd0;
    localparam logic [1:0] CMD_CALIBRATE = 2'd1;
    localparam logic [1:0] CMD_READ_GAIN = 2'd2;
    localparam logic [1:0] CMD_UPLOAD    = 2'd3;

    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic wr_byte;
        logic rd_hi;
        logic rd_lo;
        logic emit_one;
        logic emit_gain;
        logic gain_clr;
        logic gain_inc;
    } sfrcd_cmd_t;

    typedef struct packed {
        logic frame_done;
        logic is_upload;
        logic out_free;
        logic last_gain;
    } sfrcd_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/sfrcd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfrcd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sfrcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/sfrcd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfrcd_ctrl
// Controller: takes bytes, then sequences decode and gain word readout.
// ----------------------------------------------------------------------------
module sfrcd_ctrl
    import sfrcd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire sfrcd_sts_t sts,
    output sfrcd_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_CLASS     = 3'd1;
    localparam logic [2:0] ST_EMIT_ONE  = 3'd2;
    localparam logic [2:0] ST_RD_HI     = 3'd3;
    localparam logic [2:0] ST_RD_LO     = 3'd4;
    localparam logic [2:0] ST_EMIT_GAIN = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.wr_byte = s_tvalid;
                if (s_tvalid && sts.frame_done)
                begin
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS:
            begin
                cmd.gain_clr = 1'b1;
                state_next   = sts.is_upload ? ST_RD_HI : ST_EMIT_ONE;
            end
            ST_EMIT_ONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_one = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_RD_HI:
            begin
                cmd.rd_hi  = 1'b1;
                state_next = ST_RD_LO;
            end
            ST_RD_LO:
            begin
                cmd.rd_lo  = 1'b1;
                state_next = ST_EMIT_GAIN;
            end
            ST_EMIT_GAIN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_gain = 1'b1;
                    if (sts.last_gain)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.gain_inc = 1'b1;
                        state_next   = ST_RD_HI;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/sfrcd_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfrcd_dp
// Datapath: capture index, frame buffer, header decode, output register.
// ----------------------------------------------------------------------------
module sfrcd_dp
    import sfrcd_pkg::*;
#(
    parameter int FRAME_LEN = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [7:0]            rx_byte,
    input  wire logic                  cfg_we,
    input  wire logic [7:0]            cfg_data,
    input  wire sfrcd_cmd_t            cmd,
    output sfrcd_sts_t                 sts,
    input  wire logic                  m_tready,
    output logic                       m_tvalid,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tlast
);

    localparam int AW = $clog2(FRAME_LEN);

    logic [7:0]    start_reg;
    logic [AW-1:0] widx_reg;
    logic [AW-1:0] widx_next;
    logic          capt_reg;
    logic          capt_next;
    logic          capture_on;
    logic          at_end;
    logic [7:0]    hdr_reg [5];
    logic [7:0]    hi_reg;
    logic [3:0]    gain_reg;
    logic [7:0]    rd_data;
    logic [AW-1:0] rd_addr;
    logic          out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic          out_last_reg;
    logic [1:0]    class_cmd;
    logic          hdr_ok;

    assign capture_on = capt_reg || (rx_byte == start_reg);
    assign at_end     = (widx_reg == AW'(FRAME_LEN - 1));

    always_comb
    begin
        widx_next = widx_reg;
        capt_next = capt_reg;
        if (cmd.wr_byte && capture_on)
        begin
            widx_next = at_end ? '0 : widx_reg + 1'b1;
            capt_next = !at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_RST;
            widx_reg  <= '0;
            capt_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                start_reg <= cfg_data;
            end
            widx_reg <= widx_next;
            capt_reg <= capt_next;
        end
    end

    // hold header bytes as they arrive; latch the high gain byte on rd_lo
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 5; i++)
        begin
            if (cmd.wr_byte && capture_on && (widx_reg == AW'(i)))
            begin
                hdr_reg[i] <= rx_byte;
            end
        end
        if (cmd.rd_lo)
        begin
            hi_reg <= rd_data;
        end
    end

    assign hdr_ok = (hdr_reg[0] == HDR0) && (hdr_reg[1] == HDR1) && (hdr_reg[2] == HDR2);

    always_comb
    begin
        class_cmd = CMD_INVALID;
        if (hdr_ok)
        begin
            if ((hdr_reg[3] == OP_CAL3) && (hdr_reg[4] == OP_CAL4))
            begin
                class_cmd = CMD_CALIBRATE;
            end
            else if (hdr_reg[3] == OP_READ)
            begin
                class_cmd = CMD_READ_GAIN;
            end
            else if (hdr_reg[3] == OP_LOAD)
            begin
                class_cmd = CMD_UPLOAD;
            end
        end
    end

    assign rd_addr = AW'(GAIN_BASE) + AW'({gain_reg, cmd.rd_lo});

    sfrcd_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_LEN)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_byte && capture_on),
        .wr_addr (widx_reg),
        .wr_data (rx_byte),
        .rd_en   (cmd.rd_hi || cmd.rd_lo),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.gain_clr)
            begin
                gain_reg <= '0;
            end
            else if (cmd.gain_inc)
            begin
                gain_reg <= gain_reg + 1'b1;
            end
            if (cmd.emit_one || cmd.emit_gain)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_one)
        begin
            out_data_reg <= {2'b00, 16'h0000, 4'h0, class_cmd};
            out_last_reg <= 1'b1;
        end
        else if (cmd.emit_gain)
        begin
            out_data_reg <= {2'b00, hi_reg, rd_data, gain_reg, CMD_UPLOAD};
            out_last_reg <= (gain_reg == GAIN_LAST);
        end
    end

    assign sts.frame_done = capture_on && at_end;
    assign sts.is_upload  = (class_cmd == CMD_UPLOAD);
    assign sts.out_free   = !out_valid_reg || m_tready;
    assign sts.last_gain  = (gain_reg == GAIN_LAST);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

FILE: rtl/core/sync_frame_receiver_command_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sync_frame_receiver_command_decoder_core
// Frame capture on a start byte, header decode and gain word readout.
// ----------------------------------------------------------------------------
// A byte equal to start_byte opens a frame of FRAME_LEN bytes, stored in a
// frame buffer. The byte that completes a frame is followed by decode: a
// classify state, then one result word (invalid, calibrate remote, read
// gains), or for an upload nine gain words, each read as two bytes through
// the single read port of the frame buffer (states RD_HI, RD_LO) and then
// emitted (state EMIT_GAIN).
// Output words wait in a register; a stalled output holds the next decode.
module sync_frame_receiver_command_decoder_core
    import sfrcd_pkg::*;
#(
    parameter int FRAME_LEN = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] rx_byte
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [1:0] command, [5:2] gain_index,
                                                  // [21:6] gain_value, [23:22] zero
    output logic                       m_tlast,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [7:0]            cfg_data   // start_byte
);

    sfrcd_cmd_t cmd;
    sfrcd_sts_t sts;

    assign cfg_ready = 1'b1;

    sfrcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sfrcd_dp #(
        .FRAME_LEN (FRAME_LEN)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (s_tdata),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

FILE: rtl/core/sfrcd_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfrcd_chk
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module sfrcd_chk
    import sfrcd_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic                  m_tlast
);

    logic [1:0]  f_cmd;
    logic [3:0]  f_idx;
    logic [15:0] f_val;

    assign f_cmd = m_tdata[1:0];
    assign f_idx = m_tdata[5:2];
    assign f_val = m_tdata[21:6];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> f_idx <= GAIN_LAST)
        else $error("gain index out of range");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (f_cmd != CMD_UPLOAD) |-> m_tlast && (f_idx == 4'd0) && (f_val == 16'd0))
        else $error("non-upload word malformed");

    a_upload_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (f_cmd == CMD_UPLOAD) |-> (m_tlast == (f_idx == GAIN_LAST)))
        else $error("upload last flag mismatch");

endmodule

bind sync_frame_receiver_command_decoder_core sfrcd_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sync frame receiver and command decoder.
// ----------------------------------------------------------------------------
// Serial bytes go in as single words on the slave stream. Each frame is
// scored by a behavioral decoder that tracks capture state, the frame buffer
// and the start byte register. Its result words wait in a queue and are
// compared field by field with the master stream. A short table of directed
// frames comes first. Random frames follow, one under a changed start byte,
// across three flow control profiles.
// ----------------------------------------------------------------------------
module testbench;
    import sfrcd_pkg::*;

    localparam int FRAME_LEN   = 32;
    localparam int ROWS        = 2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYC  = 40;

    typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_START, FILL_RAND} fill_t;

    typedef struct packed {
        logic [3:0] noise;
        logic [7:0] h1;
        logic [7:0] h2;
        logic [7:0] h3;
        logic [7:0] h4;
        fill_t      fill;
        logic       typed;
        logic [1:0] cmd;
    } frame_row_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  idx;
        logic [15:0] val;
        logic        last;
    } decoded_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [7:0]            cfg_data  = 8'h00;

    logic [7:0] capt_buf [FRAME_LEN];
    int         capt_ptr    = 0;
    logic       capt_on     = 1'b0;
    logic [7:0] start_cfg   = START_RST;
    decoded_t   decoded_q [$];
    int         errors      = 0;
    int         cycles      = 0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;

    sync_frame_receiver_command_decoder_core #(
        .FRAME_LEN (FRAME_LEN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Capture, classify and expand one accepted byte; returns words queued.
    function automatic int decode_byte(input logic [7:0] b);
        logic [1:0] cmd;
        decoded_t   w;
        int         k;
        if (b == start_cfg)
            capt_on = 1'b1;
        if (!capt_on)
            return 0;
        capt_buf[capt_ptr] = b;
        capt_ptr++;
        if (capt_ptr < FRAME_LEN)
            return 0;
        capt_ptr = 0;
        capt_on  = 1'b0;
        if (capt_buf[0] != HDR0 || capt_buf[1] != HDR1 || capt_buf[2] != HDR2)
            cmd = CMD_INVALID;
        else if (capt_buf[3] == OP_CAL3 && capt_buf[4] == OP_CAL4)
            cmd = CMD_CALIBRATE;
        else if (capt_buf[3] == OP_READ)
            cmd = CMD_READ_GAIN;
        else if (capt_buf[3] == OP_LOAD)
            cmd = CMD_UPLOAD;
        else
            cmd = CMD_INVALID;
        if (cmd != CMD_UPLOAD)
        begin
            w.cmd  = cmd;
            w.idx  = '0;
            w.val  = '0;
            w.last = 1'b1;
            decoded_q.push_back(w);
            return 1;
        end
        for (k = 0; k < GAIN_COUNT; k++)
        begin
            w.cmd  = CMD_UPLOAD;
            w.idx  = 4'(k);
            w.val  = {capt_buf[GAIN_BASE + 2 * k], capt_buf[GAIN_BASE + 2 * k + 1]};
            w.last = (k == GAIN_COUNT - 1);
            decoded_q.push_back(w);
        end
        return GAIN_COUNT;
    endfunction

    // Drive one word; a typed row replaces the decoded word with its own.
    task automatic send_byte(input logic [7:0] b, input logic typed, input logic [1:0] tcmd);
        int       n;
        decoded_t w;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        n = decode_byte(b);
        if (typed && n != 0)
        begin
            w      = decoded_q.pop_back();
            w.cmd  = tcmd;
            w.idx  = '0;
            w.val  = '0;
            w.last = 1'b1;
            decoded_q.push_back(w);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_start(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        start_cfg = v;
    endtask

    task automatic random_frame();
        logic [7:0] fb [FRAME_LEN];
        logic [7:0] nb;
        int         kind;
        int         i;
        kind = $urandom_range(9);
        repeat ($urandom_range(3))
        begin
            do nb = 8'($urandom); while (nb == start_cfg);
            send_byte(nb, 1'b0, CMD_INVALID);
        end
        for (i = 0; i < FRAME_LEN; i++)
            case ($urandom_range(7))
                0:       fb[i] = start_cfg;
                1:       fb[i] = 8'h00;
                2:       fb[i] = 8'hFF;
                default: fb[i] = 8'($urandom);
            endcase
        fb[0] = start_cfg;
        if (kind < 9)
        begin
            fb[1] = HDR1;
            fb[2] = HDR2;
            fb[3] = (kind < 6) ? OP_LOAD : (kind == 6) ? OP_CAL3 :
                    (kind == 7) ? OP_READ : 8'($urandom);
        end
        if (kind == 6)
            fb[4] = OP_CAL4;
        if (kind == 8)
            fb[1 + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
        for (i = 0; i < FRAME_LEN; i++)
            send_byte(fb[i], 1'b0, CMD_INVALID);
    endtask

    always @(posedge clk)
    begin : result_check
        decoded_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (decoded_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: tdata=%h tlast=%b", m_tdata, m_tlast);
            end
            else
            begin
                w = decoded_q.pop_front();
                if (m_tdata[1:0] !== w.cmd || m_tdata[5:2] !== w.idx ||
                    m_tdata[21:6] !== w.val || m_tlast !== w.last ||
                    m_tdata[23:22] !== 2'b00)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %0d/%0d/%h/%b got %0d/%0d/%h/%b pad %b",
                                 w.cmd, w.idx, w.val, w.last, m_tdata[1:0], m_tdata[5:2],
                                 m_tdata[21:6], m_tlast, m_tdata[23:22]);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial
    begin
        frame_row_t plan [ROWS];
        frame_row_t row;
        logic [7:0] b;
        int         r;
        int         i;
        int         p;
        int         waited;

        plan[0] = '{4'd2, HDR1, HDR2, OP_CAL3, OP_CAL4, FILL_ZERO, 1'b1, CMD_CALIBRATE};
        plan[1] = '{4'd1, HDR1, HDR2, OP_LOAD, HDR0, FILL_START, 1'b0, CMD_UPLOAD};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 20;
        rx_idle_pct = 66;
        for (r = 0; r < ROWS; r++)
        begin
            row = plan[r];
            for (i = 0; i < row.noise; i++)
                send_byte(i[0] ? 8'h00 : 8'hFF, 1'b0, CMD_INVALID);
            for (i = 0; i < FRAME_LEN; i++)
            begin
                case (i)
                    0: b = start_cfg;
                    1: b = row.h1;
                    2: b = row.h2;
                    3: b = row.h3;
                    4: b = row.h4;
                    default:
                        case (row.fill)
                            FILL_ZERO:  b = 8'h00;
                            FILL_ONES:  b = 8'hFF;
                            FILL_START: b = start_cfg;
                            default:    b = 8'($urandom);
                        endcase
                endcase
                send_byte(b, row.typed, row.cmd);
            end
        end

        for (p = 0; p < 3; p++)
        begin
            tx_idle_pct = (p == 0) ? 20 : (p == 1) ? 66 : 0;
            rx_idle_pct = (p == 0) ? 66 : (p == 1) ? 20 : 0;
            settle();
            write_start((p == 0) ? 8'h00 : START_RST);
            random_frame();
        end

        s_tvalid <= 1'b0;
        waited = 0;
        while (decoded_q.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYC) @(posedge clk);
        errors += decoded_q.size();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/sfrcd_pkg.sv
rtl/core/sfrcd_ram.sv
rtl/core/sfrcd_ctrl.sv
rtl/core/sfrcd_dp.sv
rtl/core/sync_frame_receiver_command_decoder_core.sv
rtl/core/sfrcd_chk.sv
sim/testbench.sv
